/* sv/pab_pkg.sv */
// shared types, register map and constants of the proximity alert beeper
package pab_pkg;

    // event codes
    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_TICK    = 2'd1,
        OP_CHIRP   = 2'd2,
        OP_SILENCE = 2'd3
    } op_t;

    // zone codes
    typedef enum logic [1:0] {
        ZONE_SAFE     = 2'd0,
        ZONE_WARNING  = 2'd1,
        ZONE_CRITICAL = 2'd2
    } zone_t;

    // register indexes (byte address is 4 times the index)
    typedef enum logic [2:0] {
        REG_CRITICAL_LIMIT    = 3'd0,
        REG_WARNING_LIMIT     = 3'd1,
        REG_HYSTERESIS_MARGIN = 3'd2,
        REG_CRITICAL_PERIOD   = 3'd3,
        REG_WARNING_PERIOD    = 3'd4,
        REG_CRITICAL_TONE_HZ  = 3'd5,
        REG_WARNING_TONE_HZ   = 3'd6,
        REG_VOLUME_STEP       = 3'd7
    } reg_idx_t;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // register reset values
    localparam logic [15:0] RST_CRITICAL_LIMIT    = 16'd480;
    localparam logic [15:0] RST_WARNING_LIMIT     = 16'd1280;
    localparam logic [15:0] RST_HYSTERESIS_MARGIN = 16'd80;
    localparam logic [15:0] RST_CRITICAL_PERIOD   = 16'd200;
    localparam logic [15:0] RST_WARNING_PERIOD    = 16'd600;
    localparam logic [15:0] RST_CRITICAL_TONE_HZ  = 16'd2700;
    localparam logic [15:0] RST_WARNING_TONE_HZ   = 16'd2000;
    localparam logic [3:0]  RST_VOLUME_STEP       = 4'd10;

    localparam logic [7:0]  DUTY_MAX = 8'd128;

    // configuration register set
    typedef struct packed {
        logic [15:0] critical_limit;
        logic [15:0] warning_limit;
        logic [15:0] hysteresis_margin;
        logic [15:0] critical_period;
        logic [15:0] warning_period;
        logic [15:0] critical_tone_hz;
        logic [15:0] warning_tone_hz;
        logic [3:0]  volume_step;
    } cfg_t;

    // one input request
    typedef struct packed {
        op_t         operation;
        logic [15:0] distance;
        logic        distance_valid;
        logic [15:0] chirp_hz;
        logic [15:0] chirp_ms;
    } item_t;

    // one result
    typedef struct packed {
        zone_t       zone;
        logic        zone_changed;
        logic        tone_on;
        logic [15:0] tone_hz;
        logic [7:0]  duty;
    } result_t;

    // duty out of 256 for a volume step: step*128/10, steps above ten act as ten
    function automatic logic [7:0] duty_of(input logic [3:0] step);
        logic [7:0] d;
        case (step)
            4'd0:    d = 8'd0;
            4'd1:    d = 8'd12;
            4'd2:    d = 8'd25;
            4'd3:    d = 8'd38;
            4'd4:    d = 8'd51;
            4'd5:    d = 8'd64;
            4'd6:    d = 8'd76;
            4'd7:    d = 8'd89;
            4'd8:    d = 8'd102;
            4'd9:    d = 8'd115;
            default: d = DUTY_MAX;
        endcase
        return d;
    endfunction

endpackage

/* sv/pab_cfg_regs.sv */
// configuration register file behind the apb-style port
module pab_cfg_regs
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pab_pkg::ADDR_W-1:0] paddr,
    input  logic [pab_pkg::DATA_W-1:0] pwdata,
    output logic [pab_pkg::DATA_W-1:0] prdata,
    output pab_pkg::cfg_t              cfg
);

    pab_pkg::cfg_t     cfg_reg;
    pab_pkg::cfg_t     cfg_next;
    pab_pkg::reg_idx_t idx;
    logic              wr_en;

    assign idx   = pab_pkg::reg_idx_t'(paddr[pab_pkg::ADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;

    // write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                pab_pkg::REG_CRITICAL_LIMIT:    cfg_next.critical_limit    = pwdata[15:0];
                pab_pkg::REG_WARNING_LIMIT:     cfg_next.warning_limit     = pwdata[15:0];
                pab_pkg::REG_HYSTERESIS_MARGIN: cfg_next.hysteresis_margin = pwdata[15:0];
                pab_pkg::REG_CRITICAL_PERIOD:   cfg_next.critical_period   = pwdata[15:0];
                pab_pkg::REG_WARNING_PERIOD:    cfg_next.warning_period    = pwdata[15:0];
                pab_pkg::REG_CRITICAL_TONE_HZ:  cfg_next.critical_tone_hz  = pwdata[15:0];
                pab_pkg::REG_WARNING_TONE_HZ:   cfg_next.warning_tone_hz   = pwdata[15:0];
                pab_pkg::REG_VOLUME_STEP:       cfg_next.volume_step       = pwdata[3:0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.critical_limit    <= pab_pkg::RST_CRITICAL_LIMIT;
            cfg_reg.warning_limit     <= pab_pkg::RST_WARNING_LIMIT;
            cfg_reg.hysteresis_margin <= pab_pkg::RST_HYSTERESIS_MARGIN;
            cfg_reg.critical_period   <= pab_pkg::RST_CRITICAL_PERIOD;
            cfg_reg.warning_period    <= pab_pkg::RST_WARNING_PERIOD;
            cfg_reg.critical_tone_hz  <= pab_pkg::RST_CRITICAL_TONE_HZ;
            cfg_reg.warning_tone_hz   <= pab_pkg::RST_WARNING_TONE_HZ;
            cfg_reg.volume_step       <= pab_pkg::RST_VOLUME_STEP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            pab_pkg::REG_CRITICAL_LIMIT:    prdata = 32'(cfg_reg.critical_limit);
            pab_pkg::REG_WARNING_LIMIT:     prdata = 32'(cfg_reg.warning_limit);
            pab_pkg::REG_HYSTERESIS_MARGIN: prdata = 32'(cfg_reg.hysteresis_margin);
            pab_pkg::REG_CRITICAL_PERIOD:   prdata = 32'(cfg_reg.critical_period);
            pab_pkg::REG_WARNING_PERIOD:    prdata = 32'(cfg_reg.warning_period);
            pab_pkg::REG_CRITICAL_TONE_HZ:  prdata = 32'(cfg_reg.critical_tone_hz);
            pab_pkg::REG_WARNING_TONE_HZ:   prdata = 32'(cfg_reg.warning_tone_hz);
            pab_pkg::REG_VOLUME_STEP:       prdata = 32'(cfg_reg.volume_step);
            default:                        prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

/* sv/pab_core.sv */
// alert state, per-request update logic and result register
module pab_core
#(
    parameter int BEEP_TICKS  = 60,
    parameter int TIMER_WIDTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  pab_pkg::cfg_t    cfg,
    input  logic             item_valid,
    input  pab_pkg::item_t   item,
    output logic             ready,
    output logic             result_valid,
    input  logic             result_stall,
    output pab_pkg::result_t result
);

    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

    // alert state
    pab_pkg::zone_t         zone_reg, zone_next;
    logic                   tone_active_reg, tone_active_next;
    logic [TIMER_WIDTH-1:0] since_toggle_reg, since_toggle_next;
    logic                   chirp_pending_reg, chirp_pending_next;
    logic [15:0]            chirp_left_reg, chirp_left_next;
    logic [15:0]            driven_hz_reg, driven_hz_next;
    logic [7:0]             latched_duty_reg, latched_duty_next;
    logic                   changed;

    // result register
    logic                   out_valid_reg;
    pab_pkg::result_t       out_reg;

    logic                   fire;

    // zone sorting helpers
    logic [16:0]            crit_lim;
    logic [16:0]            warn_lim;
    pab_pkg::zone_t         sorted;

    // tick helpers
    logic [TIMER_WIDTH-1:0] since_inc;
    logic [15:0]            left_dec;
    logic [15:0]            period;
    logic [15:0]            zone_hz;
    logic                   beep_done;
    logic                   gap_done;

    assign ready = !out_valid_reg || !result_stall;
    assign fire  = item_valid && ready;

    // limits widened by the margin while in a more severe zone
    always_comb
    begin
        crit_lim = {1'b0, cfg.critical_limit};
        warn_lim = {1'b0, cfg.warning_limit};
        if (zone_reg == pab_pkg::ZONE_CRITICAL)
            crit_lim = crit_lim + {1'b0, cfg.hysteresis_margin};
        if (zone_reg != pab_pkg::ZONE_SAFE)
            warn_lim = warn_lim + {1'b0, cfg.hysteresis_margin};
        if (!item.distance_valid)
            sorted = pab_pkg::ZONE_SAFE;
        else if ({1'b0, item.distance} < crit_lim)
            sorted = pab_pkg::ZONE_CRITICAL;
        else if ({1'b0, item.distance} < warn_lim)
            sorted = pab_pkg::ZONE_WARNING;
        else
            sorted = pab_pkg::ZONE_SAFE;
    end

    // saturating timers and zone pattern selection
    always_comb
    begin
        since_inc = (since_toggle_reg == TIMER_MAX) ? since_toggle_reg
                                                    : since_toggle_reg + 1'b1;
        left_dec  = (chirp_left_reg != 16'd0) ? chirp_left_reg - 16'd1 : 16'd0;
        period    = (zone_reg == pab_pkg::ZONE_CRITICAL) ? cfg.critical_period
                                                         : cfg.warning_period;
        zone_hz   = (zone_reg == pab_pkg::ZONE_CRITICAL) ? cfg.critical_tone_hz
                                                         : cfg.warning_tone_hz;
        beep_done = 32'(since_inc) >= 32'(BEEP_TICKS);
        gap_done  = 32'(since_inc) >= 32'(period);
    end

    // next state for one request
    always_comb
    begin
        zone_next          = zone_reg;
        tone_active_next   = tone_active_reg;
        since_toggle_next  = since_toggle_reg;
        chirp_pending_next = chirp_pending_reg;
        chirp_left_next    = chirp_left_reg;
        driven_hz_next     = driven_hz_reg;
        latched_duty_next  = latched_duty_reg;
        changed            = 1'b0;
        unique case (item.operation)
            pab_pkg::OP_SAMPLE:
            begin
                if (sorted != zone_reg)
                begin
                    zone_next         = sorted;
                    since_toggle_next = TIMER_MAX;
                    changed           = 1'b1;
                    if (sorted == pab_pkg::ZONE_SAFE)
                        tone_active_next = 1'b0;
                end
            end
            pab_pkg::OP_TICK:
            begin
                since_toggle_next = since_inc;
                if (chirp_pending_reg)
                begin
                    // a running chirp owns the tick
                    chirp_left_next = left_dec;
                    if (left_dec == 16'd0)
                    begin
                        chirp_pending_next = 1'b0;
                        tone_active_next   = 1'b0;
                    end
                end
                else if (zone_reg == pab_pkg::ZONE_SAFE || cfg.volume_step == 4'd0)
                begin
                    tone_active_next = 1'b0;
                end
                else if (tone_active_reg)
                begin
                    if (beep_done)
                    begin
                        tone_active_next  = 1'b0;
                        since_toggle_next = '0;
                    end
                end
                else if (gap_done)
                begin
                    tone_active_next  = 1'b1;
                    driven_hz_next    = zone_hz;
                    latched_duty_next = pab_pkg::duty_of(cfg.volume_step);
                    since_toggle_next = '0;
                end
            end
            pab_pkg::OP_CHIRP:
            begin
                if (cfg.volume_step != 4'd0)
                begin
                    tone_active_next   = 1'b1;
                    driven_hz_next     = item.chirp_hz;
                    latched_duty_next  = pab_pkg::duty_of(cfg.volume_step);
                    chirp_pending_next = 1'b1;
                    chirp_left_next    = item.chirp_ms;
                end
            end
            pab_pkg::OP_SILENCE:
            begin
                chirp_pending_next = 1'b0;
                chirp_left_next    = 16'd0;
                tone_active_next   = 1'b0;
            end
            default:
            begin
                zone_next = zone_reg;
            end
        endcase
    end

    // state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg          <= pab_pkg::ZONE_SAFE;
            tone_active_reg   <= 1'b0;
            since_toggle_reg  <= TIMER_MAX;
            chirp_pending_reg <= 1'b0;
            chirp_left_reg    <= 16'd0;
            driven_hz_reg     <= 16'd0;
            latched_duty_reg  <= 8'd0;
        end
        else if (fire)
        begin
            zone_reg          <= zone_next;
            tone_active_reg   <= tone_active_next;
            since_toggle_reg  <= since_toggle_next;
            chirp_pending_reg <= chirp_pending_next;
            chirp_left_reg    <= chirp_left_next;
            driven_hz_reg     <= driven_hz_next;
            latched_duty_reg  <= latched_duty_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ready)
            out_valid_reg <= item_valid;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg.zone         <= zone_next;
            out_reg.zone_changed <= changed;
            out_reg.tone_on      <= tone_active_next;
            out_reg.tone_hz      <= driven_hz_next;
            out_reg.duty         <= tone_active_next ? latched_duty_next : 8'd0;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // silent tone reports zero duty
    a_duty_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.tone_on |-> out_reg.duty == 8'd0)
        else $error("duty nonzero while tone is off");

    // latched duty stays within the volume scale
    a_duty_max: assert property (@(posedge clk) disable iff (!rst_n)
        latched_duty_reg <= pab_pkg::DUTY_MAX)
        else $error("latched duty above maximum");

    // chirp time is zero whenever no chirp is pending
    a_chirp_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !chirp_pending_reg |-> chirp_left_reg == 16'd0)
        else $error("chirp time left without pending chirp");

    // a zone change always rearms the beep timer
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        fire && changed |=> since_toggle_reg == TIMER_MAX)
        else $error("zone change did not rearm beep timer");

endmodule

/* sv/proximity_alert_beeper_unit.sv */
// top level of the proximity alert beeper
//
// Requests (distance sample, 1 ms tick, chirp request, silence) arrive on the
// item channel (item_valid / item_stall with one port per field); every
// request gives exactly one result on the result channel (result_valid /
// result_stall). A request taken sits in the input register; while the core
// is ready it is evaluated against the alert state and the result is written
// into the result register, where it stays until the result is taken.
// Throughput, without result_stall, is one request per cycle; the zone, tone
// and timer update is a single short logic stage fed by the input register.
// When result_stall holds a waiting result, the input register still takes
// one request if empty, then item_stall rises until the result is taken.
// Reset clears the state: zone safe, tone off, no chirp, beep timer
// saturated so the first beep of a new zone fires on the next tick, and
// registers back to their defaults. The user must write registers through
// the apb-style port only while no request is in flight (not enforced).
module proximity_alert_beeper_unit
#(
    parameter int BEEP_TICKS  = 60,
    parameter int TIMER_WIDTH = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pab_pkg::ADDR_W-1:0] paddr,
    input  logic [pab_pkg::DATA_W-1:0] pwdata,
    output logic [pab_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    // request channel
    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic [1:0]                 operation,
    input  logic [15:0]                distance,
    input  logic                       distance_valid,
    input  logic [15:0]                chirp_hz,
    input  logic [15:0]                chirp_ms,
    // result channel
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [1:0]                 zone,
    output logic                       zone_changed,
    output logic                       tone_on,
    output logic [15:0]                tone_hz,
    output logic [7:0]                 duty
);

    pab_pkg::cfg_t    cfg;
    pab_pkg::result_t result;
    pab_pkg::item_t   item_reg;
    logic             item_valid_reg;
    logic             core_ready;
    logic             take;

    assign pready = 1'b1;

    pab_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // input register: refills when empty or when the core consumes it
    assign take       = !item_valid_reg || core_ready;
    assign item_stall = !take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (take)
            item_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take && item_valid)
        begin
            item_reg.operation      <= pab_pkg::op_t'(operation);
            item_reg.distance       <= distance;
            item_reg.distance_valid <= distance_valid;
            item_reg.chirp_hz       <= chirp_hz;
            item_reg.chirp_ms       <= chirp_ms;
        end
    end

    pab_core
    #(
        .BEEP_TICKS  (BEEP_TICKS),
        .TIMER_WIDTH (TIMER_WIDTH)
    )
    u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (item_valid_reg),
        .item         (item_reg),
        .ready        (core_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // result fields
    assign zone         = result.zone;
    assign zone_changed = result.zone_changed;
    assign tone_on      = result.tone_on;
    assign tone_hz      = result.tone_hz;
    assign duty         = result.duty;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// self-checking testbench of the proximity alert beeper: directed and random requests
module tb_top;

    localparam int BEEP_TICKS = 60;
    localparam int CYCLE_LIMIT = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // configuration port
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [pab_pkg::ADDR_W-1:0] paddr = '0;
    logic [pab_pkg::DATA_W-1:0] pwdata = '0;
    logic [pab_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    // request channel
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic [1:0]  operation = '0;
    logic [15:0] distance = '0;
    logic        distance_valid = 1'b0;
    logic [15:0] chirp_hz = '0;
    logic [15:0] chirp_ms = '0;

    // result channel
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [1:0]  zone;
    logic        zone_changed;
    logic        tone_on;
    logic [15:0] tone_hz;
    logic [7:0]  duty;

    // stimulus and scoreboard storage
    pab_pkg::item_t   request_q[$];
    pab_pkg::result_t due_results[$];
    int               mismatches = 0;
    int               cycles = 0;
    int               gap_pct = 15;
    int               stall_pct = 15;

    // shadow copy of the registers and the alert state
    pab_pkg::cfg_t  cfg_m;
    pab_pkg::zone_t zone_q;
    logic           tone_q;
    logic [15:0]    since_q;
    logic           chirp_q;
    logic [15:0]    chirp_left_q;
    logic [15:0]    hz_q;
    logic [7:0]     duty_q;

    proximity_alert_beeper_unit #(
        .BEEP_TICKS  (BEEP_TICKS),
        .TIMER_WIDTH (16)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .operation      (operation),
        .distance       (distance),
        .distance_valid (distance_valid),
        .chirp_hz       (chirp_hz),
        .chirp_ms       (chirp_ms),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .zone           (zone),
        .zone_changed   (zone_changed),
        .tone_on        (tone_on),
        .tone_hz        (tone_hz),
        .duty           (duty)
    );

    always #2 clk = ~clk;

    // switch the tone on and latch the duty of the current volume
    function automatic void tone_start(logic [15:0] hz);
        int vol;
        vol = (cfg_m.volume_step > 4'd10) ? 10 : int'(cfg_m.volume_step);
        hz_q = hz;
        duty_q = 8'((vol * 128) / 10);
        tone_q = 1'b1;
    endfunction

    // apply one request to the shadow state and return the result it gives
    function automatic pab_pkg::result_t beeper_step(pab_pkg::item_t it);
        pab_pkg::result_t r;
        pab_pkg::zone_t   nz;
        logic [16:0]      crit_lim;
        logic [16:0]      warn_lim;
        logic [15:0]      period;
        logic [15:0]      hz;
        logic             changed;
        changed = 1'b0;
        case (it.operation)
            pab_pkg::OP_SAMPLE:
            begin
                // limits widen while in a more severe zone
                crit_lim = {1'b0, cfg_m.critical_limit};
                warn_lim = {1'b0, cfg_m.warning_limit};
                if (zone_q == pab_pkg::ZONE_CRITICAL)
                    crit_lim = crit_lim + {1'b0, cfg_m.hysteresis_margin};
                if (zone_q != pab_pkg::ZONE_SAFE)
                    warn_lim = warn_lim + {1'b0, cfg_m.hysteresis_margin};
                if (!it.distance_valid)
                    nz = pab_pkg::ZONE_SAFE;
                else if ({1'b0, it.distance} < crit_lim)
                    nz = pab_pkg::ZONE_CRITICAL;
                else if ({1'b0, it.distance} < warn_lim)
                    nz = pab_pkg::ZONE_WARNING;
                else
                    nz = pab_pkg::ZONE_SAFE;
                if (nz != zone_q)
                begin
                    zone_q = nz;
                    if (nz == pab_pkg::ZONE_SAFE)
                        tone_q = 1'b0;
                    since_q = '1;
                    changed = 1'b1;
                end
            end
            pab_pkg::OP_TICK:
            begin
                if (since_q != 16'hFFFF)
                    since_q = since_q + 16'd1;
                if (chirp_q)
                begin
                    // chirp owns the tick until its time runs out
                    if (chirp_left_q != 16'd0)
                        chirp_left_q = chirp_left_q - 16'd1;
                    if (chirp_left_q == 16'd0)
                    begin
                        chirp_q = 1'b0;
                        tone_q = 1'b0;
                    end
                end
                else if (zone_q == pab_pkg::ZONE_SAFE || cfg_m.volume_step == 4'd0)
                    tone_q = 1'b0;
                else
                begin
                    // zone beep pattern
                    period = (zone_q == pab_pkg::ZONE_CRITICAL) ? cfg_m.critical_period
                                                                : cfg_m.warning_period;
                    hz = (zone_q == pab_pkg::ZONE_CRITICAL) ? cfg_m.critical_tone_hz
                                                            : cfg_m.warning_tone_hz;
                    if (tone_q)
                    begin
                        if (since_q >= 16'(BEEP_TICKS))
                        begin
                            tone_q = 1'b0;
                            since_q = '0;
                        end
                    end
                    else if (since_q >= period)
                    begin
                        tone_start(hz);
                        since_q = '0;
                    end
                end
            end
            pab_pkg::OP_CHIRP:
            begin
                if (cfg_m.volume_step != 4'd0)
                begin
                    tone_start(it.chirp_hz);
                    chirp_q = 1'b1;
                    chirp_left_q = it.chirp_ms;
                end
            end
            default:
            begin
                chirp_q = 1'b0;
                chirp_left_q = '0;
                tone_q = 1'b0;
            end
        endcase
        r.zone = zone_q;
        r.zone_changed = changed;
        r.tone_on = tone_q;
        r.tone_hz = hz_q;
        r.duty = tone_q ? duty_q : 8'd0;
        return r;
    endfunction

    // request driver fed from the pending queue
    always @(posedge clk or negedge rst_n)
    begin : drv
        pab_pkg::item_t nxt;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                nxt.operation = pab_pkg::op_t'(operation);
                nxt.distance = distance;
                nxt.distance_valid = distance_valid;
                nxt.chirp_hz = chirp_hz;
                nxt.chirp_ms = chirp_ms;
                due_results.push_back(beeper_step(nxt));
            end
            if (!item_valid || !item_stall)
            begin
                if (request_q.size() != 0 && $urandom_range(0, 99) >= gap_pct)
                begin
                    nxt = request_q.pop_front();
                    item_valid <= 1'b1;
                    operation <= nxt.operation;
                    distance <= nxt.distance;
                    distance_valid <= nxt.distance_valid;
                    chirp_hz <= nxt.chirp_hz;
                    chirp_ms <= nxt.chirp_ms;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin : mon
        pab_pkg::result_t exp_r;
        pab_pkg::result_t got_r;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            result_stall <= ($urandom_range(0, 99) < stall_pct);
            if (result_valid && !result_stall)
            begin
                got_r.zone = pab_pkg::zone_t'(zone);
                got_r.zone_changed = zone_changed;
                got_r.tone_on = tone_on;
                got_r.tone_hz = tone_hz;
                got_r.duty = duty;
                if (due_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result at %0t: zone %0d tone %0b hz %0d duty %0d",
                                 $realtime, zone, tone_on, tone_hz, duty);
                    mismatches++;
                end
                else
                begin
                    exp_r = due_results.pop_front();
                    if (got_r.zone !== exp_r.zone || got_r.zone_changed !== exp_r.zone_changed
                        || got_r.tone_on !== exp_r.tone_on || got_r.tone_hz !== exp_r.tone_hz
                        || got_r.duty !== exp_r.duty)
                    begin
                        if (mismatches < 10)
                            $display({"mismatch at %0t: exp zone %0d chg %0b on %0b hz %0d duty %0d,",
                                      " got zone %0d chg %0b on %0b hz %0d duty %0d"},
                                     $realtime, exp_r.zone, exp_r.zone_changed, exp_r.tone_on,
                                     exp_r.tone_hz, exp_r.duty, zone, zone_changed, tone_on,
                                     tone_hz, duty);
                        mismatches++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic pab_pkg::item_t mk(pab_pkg::op_t op, logic [15:0] dist_v, logic dv,
                                          logic [15:0] hz, logic [15:0] ms);
        pab_pkg::item_t it;
        it.operation = op;
        it.distance = dist_v;
        it.distance_valid = dv;
        it.chirp_hz = hz;
        it.chirp_ms = ms;
        return it;
    endfunction

    // wait until no request is pending or in flight
    task automatic wait_drained();
        do
            @(negedge clk);
        while (request_q.size() != 0 || item_valid || due_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // apb write of one register, shadow updated at the write edge
    task automatic write_reg(pab_pkg::reg_idx_t idx, logic [15:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            pab_pkg::REG_CRITICAL_LIMIT:    cfg_m.critical_limit = val;
            pab_pkg::REG_WARNING_LIMIT:     cfg_m.warning_limit = val;
            pab_pkg::REG_HYSTERESIS_MARGIN: cfg_m.hysteresis_margin = val;
            pab_pkg::REG_CRITICAL_PERIOD:   cfg_m.critical_period = val;
            pab_pkg::REG_WARNING_PERIOD:    cfg_m.warning_period = val;
            pab_pkg::REG_CRITICAL_TONE_HZ:  cfg_m.critical_tone_hz = val;
            pab_pkg::REG_WARNING_TONE_HZ:   cfg_m.warning_tone_hz = val;
            default:                        cfg_m.volume_step = val[3:0];
        endcase
    endtask

    // write every register, then send random requests and drain
    task automatic run_phase(pab_pkg::cfg_t c, int count);
        pab_pkg::item_t it;
        int             sel;
        int             base;
        int             d;
        wait_drained();
        write_reg(pab_pkg::REG_CRITICAL_LIMIT, c.critical_limit);
        write_reg(pab_pkg::REG_WARNING_LIMIT, c.warning_limit);
        write_reg(pab_pkg::REG_HYSTERESIS_MARGIN, c.hysteresis_margin);
        write_reg(pab_pkg::REG_CRITICAL_PERIOD, c.critical_period);
        write_reg(pab_pkg::REG_WARNING_PERIOD, c.warning_period);
        write_reg(pab_pkg::REG_CRITICAL_TONE_HZ, c.critical_tone_hz);
        write_reg(pab_pkg::REG_WARNING_TONE_HZ, c.warning_tone_hz);
        write_reg(pab_pkg::REG_VOLUME_STEP, {12'd0, c.volume_step});
        for (int n = 0; n < count; n++)
        begin
            // unused fields carry random values too
            it.distance = 16'($urandom);
            it.distance_valid = ($urandom_range(0, 15) != 0);
            it.chirp_hz = 16'($urandom);
            it.chirp_ms = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 80))
                                                     : 16'($urandom);
            sel = $urandom_range(0, 99);
            if (sel < 30)
                it.operation = pab_pkg::OP_SAMPLE;
            else if (sel < 85)
                it.operation = pab_pkg::OP_TICK;
            else if (sel < 93)
                it.operation = pab_pkg::OP_CHIRP;
            else
                it.operation = pab_pkg::OP_SILENCE;
            // most distances sit close to a zone boundary
            sel = $urandom_range(0, 9);
            if (sel == 0)
                it.distance = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            else if (sel > 2)
            begin
                case ($urandom_range(0, 3))
                    0:       base = int'(c.critical_limit);
                    1:       base = int'(c.warning_limit);
                    2:       base = int'(c.critical_limit) + int'(c.hysteresis_margin);
                    default: base = int'(c.warning_limit) + int'(c.hysteresis_margin);
                endcase
                d = base + int'($urandom_range(0, 40)) - 20;
                if (d < 0)
                    d = 0;
                if (d > 65535)
                    d = 65535;
                it.distance = 16'(d);
            end
            request_q.push_back(it);
        end
        wait_drained();
    endtask

    initial
    begin
        pab_pkg::cfg_t c;

        // shadow reset state
        cfg_m.critical_limit = pab_pkg::RST_CRITICAL_LIMIT;
        cfg_m.warning_limit = pab_pkg::RST_WARNING_LIMIT;
        cfg_m.hysteresis_margin = pab_pkg::RST_HYSTERESIS_MARGIN;
        cfg_m.critical_period = pab_pkg::RST_CRITICAL_PERIOD;
        cfg_m.warning_period = pab_pkg::RST_WARNING_PERIOD;
        cfg_m.critical_tone_hz = pab_pkg::RST_CRITICAL_TONE_HZ;
        cfg_m.warning_tone_hz = pab_pkg::RST_WARNING_TONE_HZ;
        cfg_m.volume_step = pab_pkg::RST_VOLUME_STEP;
        zone_q = pab_pkg::ZONE_SAFE;
        tone_q = 1'b0;
        since_q = '1;
        chirp_q = 1'b0;
        chirp_left_q = '0;
        hz_q = '0;
        duty_q = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed requests at reset settings
        request_q.push_back(mk(pab_pkg::OP_TICK, 16'd0, 1'b1, 16'd0, 16'd0));
        request_q.push_back(mk(pab_pkg::OP_SAMPLE, 16'd0, 1'b1, 16'd0, 16'd0));
        request_q.push_back(mk(pab_pkg::OP_TICK, 16'd0, 1'b0, 16'd0, 16'd0));
        request_q.push_back(mk(pab_pkg::OP_TICK, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF));
        // invalid reading counts as safe
        request_q.push_back(mk(pab_pkg::OP_SAMPLE, 16'hFFFF, 1'b0, 16'hFFFF, 16'hFFFF));
        // zero-length chirp ends on the first tick
        request_q.push_back(mk(pab_pkg::OP_CHIRP, 16'd0, 1'b0, 16'hFFFF, 16'd0));
        request_q.push_back(mk(pab_pkg::OP_TICK, 16'd0, 1'b0, 16'd0, 16'd0));
        request_q.push_back(mk(pab_pkg::OP_CHIRP, 16'd0, 1'b1, 16'd1234, 16'd3));
        request_q.push_back(mk(pab_pkg::OP_SAMPLE, 16'd500, 1'b1, 16'd0, 16'd0));
        request_q.push_back(mk(pab_pkg::OP_SAMPLE, 16'd0, 1'b1, 16'd0, 16'd0));
        // safe while a chirp is still running
        request_q.push_back(mk(pab_pkg::OP_SAMPLE, 16'hFFFF, 1'b1, 16'd0, 16'd0));
        request_q.push_back(mk(pab_pkg::OP_TICK, 16'd0, 1'b1, 16'd0, 16'd0));
        request_q.push_back(mk(pab_pkg::OP_TICK, 16'd0, 1'b1, 16'd0, 16'd0));
        request_q.push_back(mk(pab_pkg::OP_TICK, 16'd0, 1'b1, 16'd0, 16'd0));
        // hysteresis around the warning limit
        request_q.push_back(mk(pab_pkg::OP_SAMPLE, 16'd530, 1'b1, 16'd0, 16'd0));
        request_q.push_back(mk(pab_pkg::OP_SAMPLE, 16'd1300, 1'b1, 16'd0, 16'd0));
        request_q.push_back(mk(pab_pkg::OP_SAMPLE, 16'd1360, 1'b1, 16'd0, 16'd0));
        // hysteresis around the critical limit
        request_q.push_back(mk(pab_pkg::OP_SAMPLE, 16'd0, 1'b1, 16'd0, 16'd0));
        request_q.push_back(mk(pab_pkg::OP_SAMPLE, 16'd559, 1'b1, 16'd0, 16'd0));
        request_q.push_back(mk(pab_pkg::OP_TICK, 16'd0, 1'b1, 16'd0, 16'd0));
        request_q.push_back(mk(pab_pkg::OP_SILENCE, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF));
        request_q.push_back(mk(pab_pkg::OP_CHIRP, 16'd0, 1'b1, 16'h5555, 16'hFFFF));
        wait_drained();

        // volume change while the tone is on keeps the latched duty
        write_reg(pab_pkg::REG_VOLUME_STEP, 16'd3);
        request_q.push_back(mk(pab_pkg::OP_TICK, 16'd0, 1'b1, 16'd0, 16'd0));
        request_q.push_back(mk(pab_pkg::OP_SILENCE, 16'd0, 1'b1, 16'd0, 16'd0));
        request_q.push_back(mk(pab_pkg::OP_CHIRP, 16'd0, 1'b1, 16'hAAAA, 16'd2));
        request_q.push_back(mk(pab_pkg::OP_TICK, 16'd0, 1'b1, 16'd0, 16'd0));
        wait_drained();

        // muted: chirp ignored, zone beeps stay off
        write_reg(pab_pkg::REG_VOLUME_STEP, 16'd0);
        request_q.push_back(mk(pab_pkg::OP_CHIRP, 16'd0, 1'b1, 16'd777, 16'd9));
        request_q.push_back(mk(pab_pkg::OP_TICK, 16'd0, 1'b1, 16'd0, 16'd0));
        request_q.push_back(mk(pab_pkg::OP_TICK, 16'd0, 1'b1, 16'd0, 16'd0));

        // short periods, volume above ten
        c = '{critical_limit: 16'd480, warning_limit: 16'd1280, hysteresis_margin: 16'd80,
              critical_period: 16'd5, warning_period: 16'd12, critical_tone_hz: 16'd2700,
              warning_tone_hz: 16'd2000, volume_step: 4'd15};
        run_phase(c, 150);

        // upper extremes, zero periods
        c = '{critical_limit: 16'hFFFF, warning_limit: 16'hFFFF, hysteresis_margin: 16'hFFFF,
              critical_period: 16'd0, warning_period: 16'd0, critical_tone_hz: 16'hFFFF,
              warning_tone_hz: 16'd0, volume_step: 4'd10};
        run_phase(c, 100);

        // lower extremes
        c = '{critical_limit: 16'd0, warning_limit: 16'd0, hysteresis_margin: 16'd0,
              critical_period: 16'hFFFF, warning_period: 16'hFFFF, critical_tone_hz: 16'd0,
              warning_tone_hz: 16'hFFFF, volume_step: 4'd1};
        run_phase(c, 50);

        // random settings, one phase without any idling
        for (int p = 0; p < 4; p++)
        begin
            c.critical_limit = 16'($urandom_range(0, 1500));
            c.warning_limit = c.critical_limit + 16'($urandom_range(0, 1500));
            c.hysteresis_margin = 16'($urandom_range(0, 400));
            c.critical_period = 16'($urandom_range(0, 70));
            c.warning_period = 16'($urandom_range(0, 70));
            c.critical_tone_hz = 16'($urandom);
            c.warning_tone_hz = 16'($urandom);
            c.volume_step = 4'($urandom_range(0, 15));
            gap_pct = (p == 2) ? 0 : 15;
            stall_pct = (p == 2) ? 0 : 15;
            run_phase(c, 100);
        end

        repeat (20) @(negedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* proximity_alert_beeper_unit.f */
sv/pab_pkg.sv
sv/pab_cfg_regs.sv
sv/pab_core.sv
sv/proximity_alert_beeper_unit.sv
dv/tb_top.sv
